FILE: src/force_sensor_frame_parser_defines.svh
// Assertion macros used by the checker file fsfp_checker.sv.
`ifndef FORCE_SENSOR_FRAME_PARSER_DEFINES_SVH
`define FORCE_SENSOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define FSFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define FSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fsfp_pkg.sv
`timescale 1ns / 1ps

package fsfp_pkg;

    localparam logic [7:0] HDR_BYTE = 8'd55;
    localparam logic [7:0] SEL_66   = 8'd66;
    localparam logic [7:0] SEL_67   = 8'd67;
    localparam logic [7:0] SEL_68   = 8'd68;
    localparam logic [7:0] SEL_94   = 8'd94;

    localparam logic REG_RAW_MASK  = 1'b0;
    localparam logic REG_RAW_MATCH = 1'b1;

    localparam int PHASE_W = 7;

    typedef enum logic [2:0] {
        KIND_CONFIG = 3'd0,
        KIND_RAW    = 3'd1,
        KIND_FORCE  = 3'd2,
        KIND_TEMP   = 3'd3,
        KIND_COMP   = 3'd4,
        KIND_END    = 3'd5
    } item_kind_t;

    typedef enum logic [1:0] {
        FMT_66 = 2'd0,
        FMT_67 = 2'd1,
        FMT_68 = 2'd2,
        FMT_94 = 2'd3
    } frame_format_t;

    typedef enum logic [1:0] {
        CHK_NONE = 2'd0,
        CHK_OK   = 2'd1,
        CHK_BAD  = 2'd2
    } check_status_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        frame_format_t      layout;
        logic               raw_flag;
        logic [7:0]         hold;
        logic [7:0]         sum_b;
        logic [15:0]        sum_w;
    } parse_state_t;

    typedef struct packed {
        frame_format_t fmt;
        item_kind_t    kind;
        logic [3:0]    idx;
        logic [15:0]   value;
        check_status_t status;
        logic          last;
    } parse_result_t;

    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] match;
    } cfg_t;

    typedef struct packed {
        item_kind_t kind;
        logic [3:0] idx;
    } word_class_t;

    // Body bytes taken by words (twice the word count).
    function automatic logic [PHASE_W-1:0] word_bytes(input frame_format_t layout,
                                                      input logic raw_flag);
        logic [PHASE_W-1:0] n;
        case (layout)
            FMT_66:  n = PHASE_W'(8);
            FMT_67:  n = raw_flag ? PHASE_W'(10) : PHASE_W'(8);
            FMT_68:  n = PHASE_W'(24);
            FMT_94:  n = raw_flag ? PHASE_W'(40) : PHASE_W'(32);
            default: n = PHASE_W'(8);
        endcase
        return n;
    endfunction

    function automatic word_class_t classify_word(input frame_format_t layout,
                                                  input logic raw_flag,
                                                  input logic [4:0] w);
        word_class_t c;
        logic [1:0]  g;
        logic [4:0]  base;
        logic [4:0]  r;
        logic [4:0]  sub;
        c.kind = KIND_RAW;
        c.idx  = w[3:0];
        g      = 2'd0;
        base   = 5'd0;
        r      = 5'd0;
        sub    = 5'd0;
        case (layout)
            FMT_66: begin
                c.kind = KIND_RAW;
                c.idx  = w[3:0];
            end
            FMT_67: begin
                if (w < (raw_flag ? 5'd4 : 5'd3)) begin
                    c.kind = raw_flag ? KIND_RAW : KIND_FORCE;
                    c.idx  = w[3:0];
                end else begin
                    c.kind = KIND_TEMP;
                    c.idx  = 4'd0;
                end
            end
            FMT_68: begin
                if (w < 5'd3) begin
                    c.kind = KIND_FORCE;
                    c.idx  = w[3:0];
                end else if (w == 5'd3) begin
                    c.kind = KIND_TEMP;
                    c.idx  = 4'd0;
                end else if (w < 5'd8) begin
                    sub    = w - 5'd4;
                    c.kind = KIND_RAW;
                    c.idx  = sub[3:0];
                end else begin
                    sub    = w - 5'd8;
                    c.kind = KIND_COMP;
                    c.idx  = sub[3:0];
                end
            end
            FMT_94: begin
                // groups of 5 words (raw) or 4 words (force), temperature last
                if (raw_flag) begin
                    if (w >= 5'd15)      g = 2'd3;
                    else if (w >= 5'd10) g = 2'd2;
                    else if (w >= 5'd5)  g = 2'd1;
                    else                 g = 2'd0;
                    base = {1'b0, g, 2'b00} + {3'b000, g};
                    r    = w - base;
                end else begin
                    g = w[3:2];
                    r = {3'b000, w[1:0]};
                end
                if (r == (raw_flag ? 5'd4 : 5'd3)) begin
                    c.kind = KIND_TEMP;
                    c.idx  = {2'b00, g};
                end else begin
                    sub    = w - {3'b000, g};
                    c.kind = raw_flag ? KIND_RAW : KIND_FORCE;
                    c.idx  = sub[3:0];
                end
            end
            default: begin
                c.kind = KIND_RAW;
                c.idx  = w[3:0];
            end
        endcase
        return c;
    endfunction

endpackage

FILE: src/force_sensor_frame_parser.sv
`timescale 1ns / 1ps
// Channel  | Dir | Ports                                | Carries
// s_       | in  | s_tvalid s_tready s_tdata[7:0]       | one received byte
// m_       | out | m_tvalid m_tready m_tdata m_tuser    | decoded word, config byte
//          |     | m_tlast                              | or frame end
// APB      | in  | psel penable pwrite paddr pwdata ... | raw mode mask / match
//
// One byte per cycle sustained while m_ is not stalled: input register, combinational decode, result register.
// A byte's result passes from the input register through the decode into the result register, which drives m_.
// Reset (aresetn low, synchronous) empties both registers and restarts the header hunt.
// A stall on m_ holds the result; s_tready drops only when the input register
// holds a byte whose decode is blocked by a result not yet taken.

module force_sensor_frame_parser
    import fsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] item_index, [19:4] item_value,
                                   // [21:20] check_status, [23:22] zero
    output logic [4:0]  m_tuser,   // [1:0] frame_format, [4:2] item_kind
    output logic        m_tlast,   // frame_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t          cfg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic          res_valid;
    parse_result_t res;
    logic          m_valid_reg;
    parse_result_t out_res_reg;
    logic          out_free;
    logic          fire;

    fsfp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fsfp_step u_step (
        .st        (state_reg),
        .cfg       (cfg),
        .rx_byte   (in_byte_reg),
        .st_next   (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            state_reg.phase   <= '0;
            state_reg.layout  <= FMT_66;
            state_reg.raw_flag <= 1'b0;
            state_reg.hold    <= 8'd0;
            state_reg.sum_b   <= 8'd0;
            state_reg.sum_w   <= 16'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                m_valid_reg <= fire && res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (fire && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.status, out_res_reg.value, out_res_reg.idx};
    assign m_tuser  = {out_res_reg.kind, out_res_reg.fmt};
    assign m_tlast  = out_res_reg.last;

endmodule

FILE: src/fsfp_apb_regs.sv
`timescale 1ns / 1ps

module fsfp_apb_regs
    import fsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] mask_reg;
    logic [7:0] match_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= 8'd0;
            match_reg <= 8'd0;
        end else if (wr_en) begin
            if (paddr[2] == REG_RAW_MASK) begin
                mask_reg <= pwdata[7:0];
            end else begin
                match_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_RAW_MATCH) ? {24'd0, match_reg} : {24'd0, mask_reg};

    assign cfg.mask  = mask_reg;
    assign cfg.match = match_reg;

endmodule

FILE: src/fsfp_step.sv
`timescale 1ns / 1ps

module fsfp_step
    import fsfp_pkg::*;
(
    input  parse_state_t  st,
    input  cfg_t          cfg,
    input  logic [7:0]    rx_byte,
    output parse_state_t  st_next,
    output logic          res_valid,
    output parse_result_t res
);

    logic [PHASE_W-1:0] pos;
    logic [PHASE_W-1:0] rel;
    logic [PHASE_W-1:0] limit;
    logic               has_cfg;
    logic [4:0]         w;
    logic [15:0]        word_val;
    word_class_t        cls;

    assign pos      = st.phase - PHASE_W'(2);
    assign has_cfg  = (st.layout != FMT_66);
    assign rel      = pos - {{(PHASE_W-1){1'b0}}, has_cfg};
    assign limit    = word_bytes(st.layout, st.raw_flag);
    assign w        = rel[5:1];
    assign word_val = {st.hold, rx_byte};
    assign cls      = classify_word(st.layout, st.raw_flag, w);

    always_comb begin
        st_next    = st;
        res_valid  = 1'b0;
        res.fmt    = st.layout;
        res.kind   = KIND_CONFIG;
        res.idx    = 4'd0;
        res.value  = 16'd0;
        res.status = CHK_NONE;
        res.last   = 1'b0;

        if (st.phase == PHASE_W'(0)) begin
            if (rx_byte == HDR_BYTE) begin
                st_next.phase = PHASE_W'(1);
            end
        end else if (st.phase == PHASE_W'(1)) begin
            st_next.sum_b = 8'd0;
            st_next.sum_w = 16'd0;
            st_next.phase = PHASE_W'(2);
            case (rx_byte)
                SEL_66:  st_next.layout = FMT_66;
                SEL_67:  st_next.layout = FMT_67;
                SEL_68:  st_next.layout = FMT_68;
                SEL_94:  st_next.layout = FMT_94;
                default: begin
                    st_next.phase = PHASE_W'(0);
                    st_next.hold  = 8'd0;
                end
            endcase
        end else if (has_cfg && pos == PHASE_W'(0)) begin
            st_next.raw_flag = ((rx_byte & cfg.mask) == cfg.match);
            st_next.sum_b    = rx_byte;
            st_next.sum_w    = {8'd0, rx_byte};
            st_next.phase    = st.phase + PHASE_W'(1);
            res_valid        = 1'b1;
            res.kind         = KIND_CONFIG;
            res.value        = {8'd0, rx_byte};
        end else if (rel < limit) begin
            if (st.layout == FMT_68) begin
                st_next.sum_w = st.sum_w + {8'd0, rx_byte};
            end
            if (!rel[0]) begin
                st_next.hold  = rx_byte;
                st_next.phase = st.phase + PHASE_W'(1);
            end else begin
                st_next.sum_b = st.sum_b + rx_byte;
                res_valid     = 1'b1;
                res.kind      = cls.kind;
                res.idx       = cls.idx;
                res.value     = word_val;
                if (st.layout == FMT_66 && w == 5'd3) begin
                    res.last      = 1'b1;
                    st_next.phase = PHASE_W'(0);
                    st_next.sum_b = 8'd0;
                    st_next.sum_w = 16'd0;
                    st_next.hold  = 8'd0;
                end else begin
                    st_next.phase = st.phase + PHASE_W'(1);
                end
            end
        end else if (st.layout == FMT_68 && rel == limit) begin
            st_next.hold  = rx_byte;
            st_next.phase = st.phase + PHASE_W'(1);
        end else begin
            res_valid = 1'b1;
            res.kind  = KIND_END;
            res.last  = 1'b1;
            case (st.layout)
                FMT_68: begin
                    res.value  = word_val;
                    res.status = (st.sum_w == word_val) ? CHK_OK : CHK_BAD;
                end
                FMT_67: begin
                    res.value  = {8'd0, rx_byte};
                    res.status = (st.sum_b == rx_byte) ? CHK_OK : CHK_BAD;
                end
                default: begin
                    res.value  = {8'd0, rx_byte};
                    res.status = CHK_NONE;
                end
            endcase
            st_next.phase = PHASE_W'(0);
            st_next.sum_b = 8'd0;
            st_next.sum_w = 16'd0;
            st_next.hold  = 8'd0;
        end
    end

endmodule

FILE: src/fsfp_checker.sv
`timescale 1ns / 1ps
`include "force_sensor_frame_parser_defines.svh"

module fsfp_checker
    import fsfp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    `FSFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
    `FSFP_ASSERT_NOW(a_end_is_last, m_tvalid && m_tuser[4:2] == KIND_END, m_tlast, "frame end without tlast")
    `FSFP_ASSERT_NOW(a_status_only_end, m_tvalid && m_tuser[4:2] != KIND_END, m_tdata[21:20] == CHK_NONE, "check status on a non-end transaction")
    `FSFP_ASSERT_NOW(a_config_byte, m_tvalid && m_tuser[4:2] == KIND_CONFIG, m_tdata[19:12] == 8'd0 && m_tdata[3:0] == 4'd0 && !m_tlast, "malformed config transaction")

endmodule

bind force_sensor_frame_parser fsfp_checker u_fsfp_checker (.*);

FILE: bench/fsfp_frame_checker.sv
`timescale 1ns / 1ps

module fsfp_frame_checker
    import fsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [3:0] item_index, [19:4] item_value,
                                   // [21:20] check_status, [23:22] zero
    input  logic [4:0]  m_tuser,   // [1:0] frame_format, [4:2] item_kind
    input  logic        m_tlast,   // frame_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    output int          mismatches,
    output int          pending
);

    localparam logic [2:0] ADDR_MASK  = {REG_RAW_MASK, 2'b00};
    localparam logic [2:0] ADDR_MATCH = {REG_RAW_MATCH, 2'b00};

    cfg_t          regs;
    int            phase;
    frame_format_t layout;
    logic          raw_flag;
    logic [7:0]    hold;
    logic [7:0]    sum8;
    logic [15:0]   sum16;
    parse_result_t expected_items[$];

    function automatic int words_in_frame();
        case (layout)
            FMT_66:  return 4;
            FMT_67:  return raw_flag ? 5 : 4;
            FMT_68:  return 12;
            default: return raw_flag ? 20 : 16;
        endcase
    endfunction

    task automatic restart_hunt();
        phase = 0;
        sum8  = '0;
        sum16 = '0;
        hold  = '0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic decode_rx_byte(input logic [7:0] c);
        int            pos;
        int            rel;
        int            nw;
        int            w;
        int            gsize;
        int            grp;
        int            rem;
        int            idx;
        item_kind_t    kind;
        logic [15:0]   value;
        check_status_t status;
        logic          last;
        parse_result_t item;
        kind   = KIND_CONFIG;
        idx    = 0;
        value  = '0;
        status = CHK_NONE;
        last   = 1'b0;
        if (phase == 0) begin
            if (c == HDR_BYTE) phase = 1;
            return;
        end
        if (phase == 1) begin
            case (c)
                SEL_66:  layout = FMT_66;
                SEL_67:  layout = FMT_67;
                SEL_68:  layout = FMT_68;
                SEL_94:  layout = FMT_94;
                default: begin
                    restart_hunt();
                    return;
                end
            endcase
            sum8  = '0;
            sum16 = '0;
            phase = 2;
            return;
        end
        pos = phase - 2;
        rel = (layout == FMT_66) ? pos : pos - 1;
        nw  = words_in_frame();
        if (rel < 0) begin
            // config byte latches the raw mode decision
            raw_flag = ((c & regs.mask) == regs.match);
            sum8     = c;
            sum16    = {8'h00, c};
            value    = {8'h00, c};
            phase++;
        end else if (rel < 2 * nw) begin
            if (layout == FMT_68) sum16 = sum16 + {8'h00, c};
            if (rel % 2 == 0) begin
                hold = c;
                phase++;
                return;
            end
            w     = rel / 2;
            value = {hold, c};
            sum8  = sum8 + c;
            case (layout)
                FMT_66: begin
                    kind = KIND_RAW;
                    idx  = w;
                end
                FMT_67: begin
                    if (w < (raw_flag ? 4 : 3)) begin
                        kind = raw_flag ? KIND_RAW : KIND_FORCE;
                        idx  = w;
                    end else begin
                        kind = KIND_TEMP;
                    end
                end
                FMT_68: begin
                    if (w < 3) begin
                        kind = KIND_FORCE;
                        idx  = w;
                    end else if (w == 3) begin
                        kind = KIND_TEMP;
                    end else if (w < 8) begin
                        kind = KIND_RAW;
                        idx  = w - 4;
                    end else begin
                        kind = KIND_COMP;
                        idx  = w - 8;
                    end
                end
                default: begin
                    gsize = raw_flag ? 5 : 4;
                    grp   = w / gsize;
                    rem   = w % gsize;
                    if (rem + 1 < gsize) begin
                        kind = raw_flag ? KIND_RAW : KIND_FORCE;
                        idx  = (gsize - 1) * grp + rem;
                    end else begin
                        kind = KIND_TEMP;
                        idx  = grp;
                    end
                end
            endcase
            if (layout == FMT_66 && w == nw - 1) begin
                last = 1'b1;
                restart_hunt();
            end else begin
                phase++;
            end
        end else begin
            if (layout == FMT_68 && rel == 2 * nw) begin
                hold = c;
                phase++;
                return;
            end
            kind = KIND_END;
            last = 1'b1;
            case (layout)
                FMT_68: begin
                    value  = {hold, c};
                    status = (value == sum16) ? CHK_OK : CHK_BAD;
                end
                FMT_67: begin
                    value  = {8'h00, c};
                    status = (c == sum8) ? CHK_OK : CHK_BAD;
                end
                default: value = {8'h00, c};
            endcase
            restart_hunt();
        end
        item.fmt    = layout;
        item.kind   = kind;
        item.idx    = 4'(idx);
        item.value  = value;
        item.status = status;
        item.last   = last;
        expected_items.insert(expected_items.size(), item);
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            regs     = '0;
            layout   = FMT_66;
            raw_flag = 1'b0;
            restart_hunt();
            expected_items.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_items.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction: expected none, actual %h %h %b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_items.pop_front();
                    check_field("frame_format", 32'(want.fmt), 32'(m_tuser[1:0]));
                    check_field("item_kind", 32'(want.kind), 32'(m_tuser[4:2]));
                    check_field("item_index", 32'(want.idx), 32'(m_tdata[3:0]));
                    check_field("item_value", 32'(want.value), 32'(m_tdata[19:4]));
                    check_field("check_status", 32'(want.status), 32'(m_tdata[21:20]));
                    check_field("frame_last", 32'(want.last), 32'(m_tlast));
                end
            end
            if (psel && penable && pready && !pwrite) begin
                if (paddr == ADDR_MASK) check_field("raw_mode_mask readback",
                                                    {24'h0, regs.mask}, prdata);
                if (paddr == ADDR_MATCH) check_field("raw_mode_match readback",
                                                     {24'h0, regs.match}, prdata);
            end
            if (s_tvalid && s_tready) decode_rx_byte(s_tdata);
            if (psel && penable && pready && pwrite) begin
                if (paddr == ADDR_MASK) regs.mask = pwdata[7:0];
                if (paddr == ADDR_MATCH) regs.match = pwdata[7:0];
            end
        end
        pending = expected_items.size();
    end

endmodule

FILE: bench/force_sensor_frame_parser_tb.sv
`timescale 1ns / 1ps

module force_sensor_frame_parser_tb;
    import fsfp_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         PHASE_BYTES    = 245;
    localparam int         NUM_PHASES     = 6;
    localparam logic [2:0] ADDR_MASK      = {REG_RAW_MASK, 2'b00};
    localparam logic [2:0] ADDR_MATCH     = {REG_RAW_MATCH, 2'b00};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          quiet_cycles;
    logic        stall_en;
    logic [7:0]  cur_mask;
    logic [7:0]  cur_match;
    logic [7:0]  tx_q[$];

    force_sensor_frame_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fsfp_frame_checker frame_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_en && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] mask, input logic [7:0] match);
        wait_drained();
        apb_access(1'b1, ADDR_MASK, {$urandom} & 32'hFFFF_FF00 | {24'h0, mask});
        apb_access(1'b1, ADDR_MATCH, {24'h0, match});
        apb_access(1'b0, ADDR_MASK, '0);
        apb_access(1'b0, ADDR_MATCH, '0);
        cur_mask  = mask;
        cur_match = match;
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (stall_en && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        tx_q.insert(tx_q.size(), b);
    endtask

    task automatic flush_queue();
        while (tx_q.size() != 0) send_byte(tx_q.pop_front());
    endtask

    task automatic queue_frame(input frame_format_t fmt);
        logic [7:0]  cfg;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  chk8;
        logic [15:0] chk16;
        logic        raw;
        logic        corrupt;
        int          nwords;
        cfg = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) cfg = (cur_match & cur_mask) | (cfg & ~cur_mask);
        raw     = ((cfg & cur_mask) == cur_match);
        corrupt = ($urandom_range(0, 3) == 0);
        chk8    = '0;
        chk16   = '0;
        case (fmt)
            FMT_66:  nwords = 4;
            FMT_67:  nwords = raw ? 5 : 4;
            FMT_68:  nwords = 12;
            default: nwords = raw ? 20 : 16;
        endcase
        queue_byte(HDR_BYTE);
        case (fmt)
            FMT_66:  queue_byte(SEL_66);
            FMT_67:  queue_byte(SEL_67);
            FMT_68:  queue_byte(SEL_68);
            default: queue_byte(SEL_94);
        endcase
        if (fmt != FMT_66) begin
            queue_byte(cfg);
            chk8  = cfg;
            chk16 = {8'h00, cfg};
        end
        repeat (nwords) begin
            hi = 8'($urandom_range(0, 255));
            lo = 8'($urandom_range(0, 255));
            queue_byte(hi);
            queue_byte(lo);
            chk8  = chk8 + lo;
            chk16 = chk16 + {8'h00, hi} + {8'h00, lo};
        end
        case (fmt)
            FMT_67: queue_byte(corrupt ? chk8 ^ 8'($urandom_range(1, 255)) : chk8);
            FMT_68: begin
                if (corrupt) chk16 = chk16 ^ 16'($urandom_range(1, 65535));
                queue_byte(chk16[15:8]);
                queue_byte(chk16[7:0]);
            end
            FMT_94: queue_byte(8'($urandom_range(0, 255)));
            default: ;
        endcase
    endtask

    task automatic queue_noise(input int style);
        logic [7:0] b;
        if (style == 0) begin
            repeat ($urandom_range(1, 6)) begin
                b = ($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255));
                queue_byte(b);
            end
        end else if (style == 1) begin
            // header followed by a bad selector, sometimes the header byte again
            b = HDR_BYTE;
            if ($urandom_range(0, 2) != 0) begin
                b = 8'($urandom_range(0, 255));
                while (b == SEL_66 || b == SEL_67 || b == SEL_68 || b == SEL_94)
                    b = 8'($urandom_range(0, 255));
            end
            queue_byte(HDR_BYTE);
            queue_byte(b);
        end else begin
            // cut-off frame: following bytes land in its body
            queue_byte(HDR_BYTE);
            case ($urandom_range(0, 3))
                0:       queue_byte(SEL_66);
                1:       queue_byte(SEL_67);
                2:       queue_byte(SEL_68);
                default: queue_byte(SEL_94);
            endcase
            repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int sent_here;
        int pick;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        stall_en  = 1'b1;
        cur_mask  = '0;
        cur_match = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // stray bytes, bad selectors, then a minimal frame with extreme words
        tx_q = '{8'h00, 8'hFF, HDR_BYTE, 8'h12, HDR_BYTE, HDR_BYTE, SEL_66,
                 HDR_BYTE, SEL_66, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h00,
                 8'h7F, 8'hFF};
        flush_queue();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       ;
                1:       set_config(8'hFF, 8'hFF);
                2:       set_config(8'h00, 8'hFF);
                3:       set_config(8'h80, 8'h00);
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            stall_en  = (ph < NUM_PHASES - 1);
            sent_here = 0;
            while (sent_here < PHASE_BYTES) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) queue_frame(frame_format_t'($urandom_range(0, 3)));
                else queue_noise(pick - 7);
                sent_here += tx_q.size();
                flush_queue();
            end
            wait_drained();
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: force_sensor_frame_parser.f
+incdir+src
src/fsfp_pkg.sv
src/fsfp_apb_regs.sv
src/fsfp_step.sv
src/force_sensor_frame_parser.sv
src/fsfp_checker.sv
bench/fsfp_frame_checker.sv
bench/force_sensor_frame_parser_tb.sv
